// ===== rtl/ssm_pkg.sv =====
// types, constants and codes shared by the swap slot manager
// no dependencies
package ssm_pkg;

    localparam int SLOTS_DEF = 256;
    localparam int BLOCKS_PER_SLOT_DEF = 8;

    localparam int PTE_W = 32;
    localparam int BLOCK_W = 20;
    localparam int FLAG_W = 12;
    localparam int IDX_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [BLOCK_W-1:0] AREA_BASE_RST = 20'd2;
    localparam logic [FLAG_W-1:0] SWAPPED_MARK_RST = 12'd512;

    localparam logic [CFG_IDX_W-1:0] CFG_AREA_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAPPED_MARK = 1'd1;

    typedef enum logic [1:0] {
        MODE_SWAP_OUT = 2'd0,
        MODE_SWAP_IN = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_FREE_ALL = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_OUT_OF_AREA = 2'd2
    } t_status;

    typedef struct packed {
        t_mode mode;
        logic [PTE_W-1:0] pte_value;
        logic [PTE_W-1:0] frame_address;
        logic [IDX_W-1:0] slot_index;
    } t_in;

    typedef struct packed {
        logic [PTE_W-1:0] new_pte;
        logic [IDX_W-1:0] slot_used;
        logic [BLOCK_W-1:0] start_block;
        t_status status;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FIND = 2'd1,
        S_PICK = 2'd2,
        S_EXEC = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic find;
        logic pick;
        logic exec;
    } t_cmd;

endpackage

// ===== rtl/ssm_ctrl.sv =====
// sequencer of the swap slot manager: steps one word through find, pick, exec
// depends on ssm_pkg
module ssm_ctrl
    import ssm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/ssm_dp.sv =====
// datapath of the swap slot manager: free bitmap, saved flag memory,
// two-level first-fit search, block to slot division and result register
// depends on ssm_pkg
module ssm_dp
    import ssm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int BLOCKS_PER_SLOT = BLOCKS_PER_SLOT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_in                   i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out                  o_result,
    output logic                  o_done
);

    localparam int SW = ($clog2(SLOTS) < 2) ? 2 : $clog2(SLOTS);
    localparam int LW = SW / 2;
    localparam int HW = SW - LW;
    localparam int NG = 2 ** HW;
    localparam int GW = 2 ** LW;
    localparam int NP = 2 ** SW;
    localparam int SPAN = SLOTS * BLOCKS_PER_SLOT;
    localparam int DIV_L = $clog2(BLOCKS_PER_SLOT);
    localparam int DIV_K = BLOCK_W + DIV_L;
    localparam longint DIV_M = ((64'd1 << DIV_K) / BLOCKS_PER_SLOT) + 1;
    localparam int PW = BLOCK_W + DIV_K + 1;
    localparam logic [NP-1:0] FREE_INIT = {NP{1'b1}} >> (NP - SLOTS);

    logic [BLOCK_W-1:0] r_area_base;
    logic [FLAG_W-1:0]  r_mark;
    logic [NP-1:0]      r_free;
    t_in                r_item;
    logic [BLOCK_W-1:0] r_diff;
    logic               r_ge;
    logic [HW-1:0]      r_grp;
    logic               r_found;
    logic               r_inrange;
    logic [SW-1:0]      r_slot;
    logic [FLAG_W-1:0]  r_rdata;
    logic [FLAG_W-1:0]  r_flags [SLOTS];
    t_out               r_out;
    t_out               n_out;
    logic               r_done;

    logic [NG-1:0]      grp_any;
    logic [HW-1:0]      grp_sel;
    logic [GW-1:0]      lo_bits;
    logic [LW-1:0]      lo_sel;
    logic [BLOCK_W-1:0] blk_in;
    logic [PW-1:0]      prod;
    logic [SW-1:0]      quot;
    logic [BLOCK_W-1:0] ofs;
    logic [BLOCK_W-1:0] st;
    logic [FLAG_W-1:0]  rd_flags;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_base <= AREA_BASE_RST;
            r_mark <= SWAPPED_MARK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AREA_BASE: r_area_base <= i_cfg_data[BLOCK_W-1:0];
                CFG_SWAPPED_MARK: r_mark <= i_cfg_data[FLAG_W-1:0];
                default: ;
            endcase
        end
    end

    // first-fit search: group level, then within the chosen group
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_any[g] = |r_free[g*GW +: GW];
        end
        grp_sel = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                grp_sel = HW'(g);
            end
        end
        lo_bits = r_free[r_grp*GW +: GW];
        lo_sel = '0;
        for (int b = GW - 1; b >= 0; b--) begin
            if (lo_bits[b]) begin
                lo_sel = LW'(b);
            end
        end
    end

    // block to slot by reciprocal multiply, exact for every 20 bit offset
    assign blk_in = i_item.pte_value[PTE_W-1 -: BLOCK_W];
    assign prod = PW'(r_diff) * PW'(DIV_M);
    assign quot = prod[DIV_K +: SW];

    assign ofs = 20'(r_slot) * 20'(BLOCKS_PER_SLOT);
    assign st = r_area_base + ofs;
    assign rd_flags = r_free[r_slot] ? '0 : r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_diff <= blk_in - r_area_base;
            r_ge <= (blk_in >= r_area_base);
        end
        if (i_cmd.find) begin
            r_grp <= grp_sel;
            r_found <= |grp_any;
            case (r_item.mode)
                MODE_SWAP_IN: begin
                    r_slot <= quot;
                    r_inrange <= r_ge && (21'(r_diff) < 21'(SPAN));
                end
                MODE_RELEASE: begin
                    r_slot <= SW'(r_item.slot_index);
                    r_inrange <= (13'(r_item.slot_index) < 13'(SLOTS));
                end
                default: begin
                    r_inrange <= 1'b0;
                end
            endcase
        end
        if (i_cmd.pick && (r_item.mode == MODE_SWAP_OUT)) begin
            r_slot <= {r_grp, lo_sel};
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    // saved flag memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_item.mode == MODE_SWAP_OUT) && r_found) begin
            r_flags[r_slot] <= r_item.pte_value[FLAG_W-1:0];
        end
        if (i_cmd.pick && (r_item.mode == MODE_SWAP_IN) && r_inrange) begin
            r_rdata <= r_flags[r_slot];
        end
    end

    // free bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= FREE_INIT;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.exec) begin
                case (r_item.mode)
                    MODE_SWAP_OUT: begin
                        if (r_found) begin
                            r_free[r_slot] <= 1'b0;
                        end
                    end
                    MODE_SWAP_IN, MODE_RELEASE: begin
                        if (r_inrange) begin
                            r_free[r_slot] <= 1'b1;
                        end
                    end
                    MODE_FREE_ALL: begin
                        r_free <= FREE_INIT;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_out = '0;
        n_out.status = ST_OK;
        case (r_item.mode)
            MODE_SWAP_OUT: begin
                if (r_found) begin
                    n_out.new_pte = (({st, {FLAG_W{1'b0}}}
                                     | {{BLOCK_W{1'b0}}, r_item.pte_value[FLAG_W-1:0]})
                                     & ~32'h1) | {{BLOCK_W{1'b0}}, r_mark};
                    n_out.slot_used = 8'(r_slot);
                    n_out.start_block = st;
                end else begin
                    n_out.status = ST_NO_SLOT;
                end
            end
            MODE_SWAP_IN: begin
                if (r_inrange) begin
                    n_out.new_pte = {r_item.frame_address[PTE_W-1 -: BLOCK_W], rd_flags}
                                    | 32'h1;
                    n_out.slot_used = 8'(r_slot);
                    n_out.start_block = r_item.pte_value[PTE_W-1 -: BLOCK_W];
                end else begin
                    n_out.status = ST_OUT_OF_AREA;
                end
            end
            MODE_RELEASE: begin
                if (r_inrange) begin
                    n_out.slot_used = 8'(r_slot);
                    n_out.start_block = st;
                end else begin
                    n_out.status = ST_OUT_OF_AREA;
                end
            end
            default: ;
        endcase
    end

    assign o_result = r_out;
    assign o_done = r_done;

endmodule

// ===== rtl/swap_slot_manager.sv =====
// top level of the swap slot manager: sequencer plus datapath
// depends on ssm_pkg, ssm_ctrl, ssm_dp
//
//   channel   ports                              transfer
//   command   i_start, o_busy, i_item            start high while busy low
//   result    o_done, o_result                   o_done high for one cycle
//   config    i_cfg_we, i_cfg_idx, i_cfg_data    write enable high
//
// a word steps through find (group search or block division), pick
// (slot search or flag memory read), exec (bitmap update, flag write), and
// the result strobe, which overlaps the next accept
// the two-level free slot search and the registered flag memory read set these steps
// reset is synchronous; every slot is free and all saved flags read as zero
// the receiver cannot stall the result
module swap_slot_manager
    import ssm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int BLOCKS_PER_SLOT = BLOCKS_PER_SLOT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in                   i_item,
    output logic                  o_done,
    output t_out                  o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;

    ssm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    ssm_dp #(
        .SLOTS           (SLOTS),
        .BLOCKS_PER_SLOT (BLOCKS_PER_SLOT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result),
        .o_done     (o_done)
    );

endmodule

// ===== dv/tb_top.sv =====
// testbench for swap_slot_manager: directed and random command words, with a slot
// ledger class that predicts every result word and checks it against the block
// depends on ssm_pkg and swap_slot_manager
module tb_top
    import ssm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PTE_W-1:0] PRESENT_BIT = 32'd1;

    class slot_ledger;
        logic [BLOCK_W-1:0] area_base;
        logic [FLAG_W-1:0]  swapped_mark;
        bit                 slot_free [SLOTS_DEF];
        logic [FLAG_W-1:0]  saved_flags [SLOTS_DEF];
        t_out               due_words [$];
        int                 mismatches;

        function void free_all_slots();
            for (int i = 0; i < SLOTS_DEF; i++) begin
                slot_free[i] = 1'b1;
                saved_flags[i] = '0;
            end
        endfunction

        function void power_on();
            area_base = AREA_BASE_RST;
            swapped_mark = SWAPPED_MARK_RST;
            mismatches = 0;
            free_all_slots();
        endfunction

        function logic [BLOCK_W-1:0] slot_base(int s);
            logic [BLOCK_W-1:0] b;
            b = area_base + BLOCK_W'(s * BLOCKS_PER_SLOT_DEF);
            return b;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_AREA_BASE) begin
                area_base = data[BLOCK_W-1:0];
            end else begin
                swapped_mark = data[FLAG_W-1:0];
            end
        endfunction

        // random slot that is free or in use, -1 if there is none
        function int pick_slot(bit want_free);
            int first;
            int s;
            first = $urandom_range(0, SLOTS_DEF - 1);
            for (int i = 0; i < SLOTS_DEF; i++) begin
                s = (first + i) % SLOTS_DEF;
                if (slot_free[s] == want_free) return s;
            end
            return -1;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void note_word(t_in w);
            t_out               r;
            int                 s;
            int unsigned        offs;
            int unsigned        q;
            logic [BLOCK_W-1:0] blk;
            logic [FLAG_W-1:0]  flags;
            r = '0;
            r.status = ST_OK;
            case (w.mode)
                MODE_SWAP_OUT: begin
                    s = -1;
                    for (int i = 0; i < SLOTS_DEF; i++) begin
                        if (s < 0 && slot_free[i]) s = i;
                    end
                    if (s < 0) begin
                        r.status = ST_NO_SLOT;
                    end else begin
                        flags = w.pte_value[FLAG_W-1:0];
                        blk = slot_base(s);
                        slot_free[s] = 1'b0;
                        saved_flags[s] = flags;
                        r.new_pte = ({blk, flags} & ~PRESENT_BIT) | PTE_W'(swapped_mark);
                        r.slot_used = IDX_W'(s);
                        r.start_block = blk;
                    end
                end
                MODE_SWAP_IN: begin
                    blk = w.pte_value[PTE_W-1:FLAG_W];
                    q = SLOTS_DEF;
                    if (blk >= area_base) begin
                        offs = 32'(blk) - 32'(area_base);
                        q = offs / BLOCKS_PER_SLOT_DEF;
                    end
                    if (q >= SLOTS_DEF) begin
                        r.status = ST_OUT_OF_AREA;
                    end else begin
                        r.new_pte = {w.frame_address[PTE_W-1:FLAG_W], saved_flags[q]}
                                    | PRESENT_BIT;
                        slot_free[q] = 1'b1;
                        saved_flags[q] = '0;
                        r.slot_used = IDX_W'(q);
                        r.start_block = blk;
                    end
                end
                MODE_RELEASE: begin
                    s = int'(w.slot_index);
                    if (s >= SLOTS_DEF) begin
                        r.status = ST_OUT_OF_AREA;
                    end else begin
                        slot_free[s] = 1'b1;
                        saved_flags[s] = '0;
                        r.slot_used = w.slot_index;
                        r.start_block = slot_base(s);
                    end
                end
                default: begin
                    free_all_slots();
                end
            endcase
            due_words.push_back(r);
        endfunction

        function void check_word(t_out got);
            t_out want;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result word with nothing due: new_pte %h slot_used %h %s",
                             $realtime, got.new_pte, got.slot_used, "(unexpected)");
                end
                return;
            end
            want = due_words.pop_front();
            if (got.new_pte !== want.new_pte || got.slot_used !== want.slot_used ||
                got.start_block !== want.start_block || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch new_pte exp %h got %h, slot_used exp %h got %h",
                             $realtime, want.new_pte, got.new_pte, want.slot_used,
                             got.slot_used);
                    $display("    start_block exp %h got %h, status exp %0d got %0d",
                             want.start_block, got.start_block, want.status, got.status);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_in                   i_item;
    logic                  o_done;
    t_out                  o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    slot_ledger ledger;

    swap_slot_manager dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) ledger.check_word(o_result);
    end

    function automatic t_in word_of(t_mode m, logic [PTE_W-1:0] pte,
                                    logic [PTE_W-1:0] frame, logic [IDX_W-1:0] idx);
        t_in w;
        w.mode = m;
        w.pte_value = pte;
        w.frame_address = frame;
        w.slot_index = idx;
        return w;
    endfunction

    function automatic t_in make_word(int p_out, int p_free);
        t_in         w;
        int          r;
        int          s;
        int unsigned blk;
        w = word_of(MODE_SWAP_OUT, $urandom, $urandom, IDX_W'($urandom));
        r = $urandom_range(0, 99);
        if (r < p_out) return w;
        if (r >= 100 - p_free) begin
            w.mode = MODE_FREE_ALL;
            return w;
        end
        if (r >= 92 - p_free) begin
            w.mode = MODE_RELEASE;
            if ($urandom_range(0, 1) == 1) begin
                s = ledger.pick_slot(1'b0);
                if (s >= 0) w.slot_index = IDX_W'(s);
            end
            return w;
        end
        w.mode = MODE_SWAP_IN;
        r = $urandom_range(0, 9);
        s = -1;
        if (r < 6) begin
            s = ledger.pick_slot(1'b0);
        end else if (r < 8) begin
            s = ledger.pick_slot(1'b1);
        end
        if (s >= 0) begin
            blk = ledger.area_base + s * BLOCKS_PER_SLOT_DEF;
            if ($urandom_range(0, 3) == 0) blk += $urandom_range(0, BLOCKS_PER_SLOT_DEF - 1);
            w.pte_value[PTE_W-1:FLAG_W] = blk[BLOCK_W-1:0];
        end else if (r == 8 && ledger.area_base > 0) begin
            blk = $urandom_range(0, ledger.area_base - 1);
            w.pte_value[PTE_W-1:FLAG_W] = blk[BLOCK_W-1:0];
        end else if (r == 9) begin
            blk = ledger.area_base + SLOTS_DEF * BLOCKS_PER_SLOT_DEF + $urandom_range(0, 64);
            w.pte_value[PTE_W-1:FLAG_W] = blk[BLOCK_W-1:0];
        end
        return w;
    endfunction

    task automatic send_word(input t_in w);
        i_start <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        ledger.note_word(w);
    endtask

    task automatic idle_gap(input int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.write_reg(idx, data);
    endtask

    task automatic run_phase(input int n, input int p_out, input int p_free, input bit gaps);
        for (int i = 0; i < n; i++) begin
            send_word(make_word(p_out, p_free));
            if (gaps && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 10));
        end
    endtask

    initial begin
        ledger = new;
        ledger.power_on();
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_AREA_BASE;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under the reset settings
        send_word(word_of(MODE_SWAP_OUT, 32'hFFFF_FFFF, 32'h0, 8'h00));
        send_word(word_of(MODE_SWAP_OUT, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF));
        send_word(word_of(MODE_SWAP_OUT, 32'h1234_5A5B, 32'h0, 8'h00));
        send_word(word_of(MODE_SWAP_IN, 32'h0000_2FFF, 32'hFFFF_FFFF, 8'h00));
        send_word(word_of(MODE_SWAP_IN, 32'h0001_1000, 32'h0000_0000, 8'h00));
        send_word(word_of(MODE_SWAP_IN, 32'h0000_2000, 32'hABCD_E123, 8'h00));
        send_word(word_of(MODE_SWAP_IN, 32'h0000_1ABC, 32'h1234_5000, 8'h00));
        send_word(word_of(MODE_SWAP_IN, 32'h0080_1000, 32'h5555_5555, 8'h00));
        send_word(word_of(MODE_SWAP_IN, 32'h0080_2000, 32'hAAAA_AAAA, 8'h00));
        send_word(word_of(MODE_SWAP_IN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        send_word(word_of(MODE_RELEASE, 32'h0, 32'h0, 8'h00));
        send_word(word_of(MODE_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        send_word(word_of(MODE_RELEASE, 32'h0, 32'h0, 8'h02));
        send_word(word_of(MODE_SWAP_OUT, 32'h0000_0E01, 32'h0, 8'h00));
        send_word(word_of(MODE_FREE_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        send_word(word_of(MODE_SWAP_OUT, 32'hAAAA_AAAA, 32'h0, 8'h00));
        send_word(word_of(MODE_SWAP_IN, 32'h0000_2555, 32'h8000_0FFF, 8'h00));

        write_reg(CFG_AREA_BASE, 20'h00000);
        write_reg(CFG_SWAPPED_MARK, 20'h00000);
        run_phase(400, 45, 2, 1'b1);

        write_reg(CFG_AREA_BASE, 20'hFFFFF);
        write_reg(CFG_SWAPPED_MARK, 20'hFFFFF);
        run_phase(300, 45, 2, 1'b1);

        // fill the table so swap-outs run out of slots
        write_reg(CFG_AREA_BASE, CFG_DATA_W'($urandom));
        write_reg(CFG_SWAPPED_MARK, CFG_DATA_W'($urandom));
        run_phase(420, 88, 0, 1'b1);

        write_reg(CFG_AREA_BASE, CFG_DATA_W'($urandom_range(0, 1000)));
        write_reg(CFG_SWAPPED_MARK, CFG_DATA_W'($urandom));
        run_phase(380, 50, 2, 1'b1);

        write_reg(CFG_AREA_BASE, CFG_DATA_W'(AREA_BASE_RST));
        write_reg(CFG_SWAPPED_MARK, CFG_DATA_W'(SWAPPED_MARK_RST));
        run_phase(300, 45, 2, 1'b0);

        drain();
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
